/* rtl/core/lfu_pr_pkg.sv */
// LFU page replacement: shared constants, types and helpers.
// No dependencies; used by every other file of the block.
package lfu_pr_pkg;

    localparam int FRAMES      = 8;
    localparam int PAGE_BITS   = 16;
    localparam int COUNT_BITS  = 16;
    localparam int IDX_BITS    = (FRAMES > 1) ? $clog2(FRAMES) : 1;
    localparam int FILL_BITS   = $clog2(FRAMES + 1);
    localparam int LIMIT_BITS  = 4;
    localparam int FAULT_BITS  = 32;
    localparam int OUT_IDX_BITS = 3;
    localparam int OUT_PAGE_BITS = 16;

    localparam logic [COUNT_BITS-1:0] COUNT_MAX  = '1;
    localparam logic [FAULT_BITS-1:0] FAULT_MAX  = '1;
    localparam logic [LIMIT_BITS-1:0] LIMIT_RESET = LIMIT_BITS'(8);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_COMMIT
    } ctrl_state_t;

    // Lookup request travelling down the cell chain.
    typedef struct packed {
        logic                  valid;
        logic [PAGE_BITS-1:0]  page;
        logic                  found;
        logic [IDX_BITS-1:0]   found_idx;
        logic                  best_valid;
        logic [IDX_BITS-1:0]   best_idx;
        logic [COUNT_BITS-1:0] best_count;
        logic [COUNT_BITS-1:0] best_age;
        logic [PAGE_BITS-1:0]  best_page;
    } probe_t;

    // Table update broadcast to every cell at the end of a request.
    typedef struct packed {
        logic                 valid;
        logic                 hit;
        logic [IDX_BITS-1:0]  idx;
        logic [PAGE_BITS-1:0] page;
    } commit_t;

    function automatic logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] v);
        return (v == COUNT_MAX) ? COUNT_MAX : v + COUNT_BITS'(1);
    endfunction

endpackage

/* rtl/core/lfu_pr_ifs.sv */
// Handshake channels of the LFU page replacement core: request, response, config.
// Depends on lfu_pr_pkg.
interface lfu_pr_req_if
    import lfu_pr_pkg::*;
();
    logic                 valid;
    logic                 ready;
    logic [PAGE_BITS-1:0] page_number;

    modport source (output valid, output page_number, input ready);
    modport sink   (input valid, input page_number, output ready);
endinterface

interface lfu_pr_rsp_if
    import lfu_pr_pkg::*;
();
    logic                     valid;
    logic                     ready;
    logic                     hit;
    logic [OUT_IDX_BITS-1:0]  frame_index;
    logic                     evicted;
    logic [OUT_PAGE_BITS-1:0] evicted_page;
    logic [FAULT_BITS-1:0]    fault_count;

    modport source (output valid, output hit, output frame_index, output evicted,
                    output evicted_page, output fault_count, input ready);
    modport sink   (input valid, input hit, input frame_index, input evicted,
                    input evicted_page, input fault_count, output ready);
endinterface

interface lfu_pr_cfg_if
    import lfu_pr_pkg::*;
();
    logic                  valid;
    logic                  ready;
    logic [LIMIT_BITS-1:0] data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

/* rtl/core/lfu_pr_cell.sv */
// One frame of the LFU table: page, use count, age and filled flag.
// Registers the lookup request on to its neighbor. Depends on lfu_pr_pkg.
module lfu_pr_cell
    import lfu_pr_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic [IDX_BITS-1:0] cell_idx,
    input  probe_t              probe_in,
    output probe_t              probe_out,
    input  commit_t             commit
);

    logic [PAGE_BITS-1:0]  page_reg,   page_next;
    logic [COUNT_BITS-1:0] count_reg,  count_next;
    logic [COUNT_BITS-1:0] age_reg,    age_next;
    logic                  filled_reg, filled_next;
    probe_t                probe_reg,  probe_next;

    logic match;
    logic better;
    logic mine;

    assign match  = filled_reg && !probe_in.found && (page_reg == probe_in.page);
    // strict compare keeps the lowest index on a full tie
    assign better = filled_reg && (!probe_in.best_valid ||
                    (count_reg < probe_in.best_count) ||
                    ((count_reg == probe_in.best_count) && (age_reg > probe_in.best_age)));
    assign mine   = commit.valid && (commit.idx == cell_idx);

    always_comb
    begin
        probe_next = probe_in;
        if (match)
        begin
            probe_next.found     = 1'b1;
            probe_next.found_idx = cell_idx;
        end
        if (better)
        begin
            probe_next.best_valid = 1'b1;
            probe_next.best_idx   = cell_idx;
            probe_next.best_count = count_reg;
            probe_next.best_age   = age_reg;
            probe_next.best_page  = page_reg;
        end
    end

    always_comb
    begin
        page_next   = page_reg;
        count_next  = count_reg;
        age_next    = age_reg;
        filled_next = filled_reg;
        if (mine && !commit.hit)
        begin
            // newly loaded frame: count 1, age 0 then aged once
            page_next   = commit.page;
            count_next  = COUNT_BITS'(1);
            age_next    = COUNT_BITS'(1);
            filled_next = 1'b1;
        end
        else if (commit.valid && filled_reg)
        begin
            age_next = sat_inc(age_reg);
            if (mine)
            begin
                count_next = sat_inc(count_reg);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= '0;
            age_reg    <= '0;
            filled_reg <= 1'b0;
            probe_reg  <= '0;
        end
        else
        begin
            count_reg  <= count_next;
            age_reg    <= age_next;
            filled_reg <= filled_next;
            probe_reg  <= probe_next;
        end
    end

    always_ff @(posedge clk)
    begin
        page_reg <= page_next;
    end

    assign probe_out = probe_reg;

endmodule

/* rtl/core/lfu_pr_ctrl.sv */
// Sequencer of the LFU core: launches a request into the cell chain, picks
// fill / hit / evict from the chain's tail and drives the response register.
// Depends on lfu_pr_pkg and lfu_pr_ifs.
module lfu_pr_ctrl
    import lfu_pr_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    lfu_pr_req_if.sink    req,
    lfu_pr_rsp_if.source  rsp,
    lfu_pr_cfg_if.sink    cfg,
    output probe_t        head,
    input  probe_t        tail,
    output commit_t       commit
);

    ctrl_state_t state_reg, state_next;

    logic [LIMIT_BITS-1:0]    limit_reg;
    logic [FILL_BITS-1:0]     fill_reg,  fill_next;
    logic [FAULT_BITS-1:0]    fault_reg, fault_next;
    probe_t                   pend_reg;

    logic                     out_valid_reg, out_valid_next;
    logic                     out_hit_reg;
    logic [IDX_BITS-1:0]      out_idx_reg;
    logic                     out_evicted_reg;
    logic [PAGE_BITS-1:0]     out_page_reg;

    logic                     accept;
    logic                     commit_fire;
    logic                     out_free;
    logic [FILL_BITS-1:0]     eff_limit;
    logic                     do_fill;
    logic [IDX_BITS-1:0]      sel_idx;

    assign cfg.ready = 1'b1;
    assign out_free  = !out_valid_reg || rsp.ready;

    always_comb
    begin
        if (limit_reg == '0)
        begin
            eff_limit = FILL_BITS'(1);
        end
        else if (int'(limit_reg) > FRAMES)
        begin
            eff_limit = FILL_BITS'(FRAMES);
        end
        else
        begin
            eff_limit = FILL_BITS'(limit_reg);
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (req.valid)
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (tail.valid)
                begin
                    state_next = ST_COMMIT;
                end
            end
            ST_COMMIT:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // state outputs
    always_comb
    begin
        req.ready   = 1'b0;
        commit_fire = 1'b0;
        case (state_reg)
            ST_IDLE:   req.ready   = 1'b1;
            ST_SCAN:   req.ready   = 1'b0;
            ST_COMMIT: commit_fire = out_free;
            default:   req.ready   = 1'b0;
        endcase
    end

    assign accept = req.valid && req.ready;

    always_comb
    begin
        head       = '0;
        head.valid = accept;
        head.page  = req.page_number;
    end

    assign do_fill = !pend_reg.found && (fill_reg < eff_limit);

    always_comb
    begin
        if (pend_reg.found)
        begin
            sel_idx = pend_reg.found_idx;
        end
        else if (do_fill)
        begin
            sel_idx = IDX_BITS'(fill_reg);
        end
        else
        begin
            sel_idx = pend_reg.best_idx;
        end
    end

    assign commit.valid = commit_fire;
    assign commit.hit   = pend_reg.found;
    assign commit.idx   = sel_idx;
    assign commit.page  = pend_reg.page;

    always_comb
    begin
        fill_next      = fill_reg;
        fault_next     = fault_reg;
        out_valid_next = out_valid_reg && !rsp.ready;
        if (commit_fire)
        begin
            out_valid_next = 1'b1;
            if (do_fill)
            begin
                fill_next = fill_reg + FILL_BITS'(1);
            end
            if (!pend_reg.found && (fault_reg != FAULT_MAX))
            begin
                fault_next = fault_reg + FAULT_BITS'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            limit_reg     <= LIMIT_RESET;
            fill_reg      <= '0;
            fault_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            fill_reg      <= fill_next;
            fault_reg     <= fault_next;
            out_valid_reg <= out_valid_next;
            if (cfg.valid)
            begin
                limit_reg <= cfg.data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (tail.valid)
        begin
            pend_reg <= tail;
        end
        if (commit_fire)
        begin
            out_hit_reg     <= pend_reg.found;
            out_idx_reg     <= sel_idx;
            out_evicted_reg <= !pend_reg.found && !do_fill;
            out_page_reg    <= (!pend_reg.found && !do_fill) ? pend_reg.best_page : '0;
        end
    end

    assign rsp.valid        = out_valid_reg;
    assign rsp.hit          = out_hit_reg;
    assign rsp.frame_index  = OUT_IDX_BITS'(out_idx_reg);
    assign rsp.evicted      = out_evicted_reg;
    assign rsp.evicted_page = OUT_PAGE_BITS'(out_page_reg);
    assign rsp.fault_count  = fault_reg;

`ifndef SYNTH
    a_tail_only_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
        tail.valid |-> (state_reg == ST_SCAN))
        else $error("chain tail valid outside scan");

    a_fill_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        int'(fill_reg) <= FRAMES)
        else $error("fill count beyond table");

    a_rsp_from_commit: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> ($past(state_reg) == ST_COMMIT))
        else $error("response raised without a commit");

    a_fault_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
        !commit_fire |=> $stable(fault_reg))
        else $error("fault total moved without a commit");
`endif

endmodule

/* rtl/core/lfu_pr_top_chain.sv */
// Row of LFU frame cells linked head to tail by their request registers.
// Depends on lfu_pr_pkg and lfu_pr_cell.
module lfu_pr_top_chain
    import lfu_pr_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  probe_t  head,
    output probe_t  tail,
    input  commit_t commit
);

    probe_t link [FRAMES+1];

    assign link[0] = head;

    for (genvar g = 0; g < FRAMES; g++)
    begin : g_cell
        lfu_pr_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .cell_idx  (IDX_BITS'(g)),
            .probe_in  (link[g]),
            .probe_out (link[g+1]),
            .commit    (commit)
        );
    end

    assign tail = link[FRAMES];

endmodule

/* rtl/core/lfu_page_replacement_core.sv */
// LFU page replacement core.
// Channels: req carries one page reference (page_number); rsp returns one
// response per request (hit, frame_index, evicted, evicted_page, fault_count);
// cfg writes frames_in_use (0 acts as 1, above 8 acts as 8).
// A request walks a row of 8 frame cells, one cell per cycle, collecting the
// first matching frame and the least-used, oldest frame. The chain's result is
// registered; then the table is updated and the response register loaded.
// Requests do not overlap: the next one is taken only after the current one
// has walked the cell row and been committed.
// req.ready is high only while no request is in flight; a finished response
// may still wait in its register while the next request walks the row.
// If rsp stalls, a finished request holds before the update until the
// response register frees, and no new request is taken meanwhile.
// cfg.ready is always high; write it only while idle.
// Reset empties the table, clears the fault total and sets frames_in_use to 8.
// Depends on lfu_pr_pkg, lfu_pr_ifs, lfu_pr_ctrl and lfu_pr_top_chain.
module lfu_page_replacement_core
    import lfu_pr_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    lfu_pr_req_if.sink   req,
    lfu_pr_rsp_if.source rsp,
    lfu_pr_cfg_if.sink   cfg
);

    probe_t  head;
    probe_t  tail;
    commit_t commit;

    lfu_pr_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .req    (req),
        .rsp    (rsp),
        .cfg    (cfg),
        .head   (head),
        .tail   (tail),
        .commit (commit)
    );

    lfu_pr_top_chain u_chain (
        .clk    (clk),
        .rst_n  (rst_n),
        .head   (head),
        .tail   (tail),
        .commit (commit)
    );

endmodule
